### rtl/core/pnsp_pkg.sv
// ----------------------------------------------------------------------------
// pnsp_pkg
// Types and constants for the phone number string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pnsp_pkg;

  localparam int unsigned NumW    = 50;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned TblDepth = 1024;

  localparam logic [CountW-1:0] CountMax = 5'd31;
  localparam logic [NumW-1:0]   CcMax    = 50'd999;

  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChLeft  = 8'd40;
  localparam logic [CharW-1:0] ChRight = 8'd41;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChSpace = 8'd32;

  typedef enum logic {
    CMD_TABLE_WRITE = 1'b0,
    CMD_CHAR        = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_PREFIX     = 4'd2,
    ST_LONG       = 4'd3,
    ST_FORMAT     = 4'd4,
    ST_RANGE      = 4'd5,
    ST_INVALID    = 4'd6,
    ST_UNASSIGNED = 4'd7,
    ST_NOSUB      = 4'd8,
    ST_LENGTH     = 4'd9
  } status_e;

  typedef enum logic [TypeW-1:0] {
    CT_INVALID    = 3'd0,
    CT_GEOGRAPHIC = 3'd1,
    CT_GLOBAL_SVC = 3'd2,
    CT_NETWORK    = 3'd3,
    CT_GROUP      = 3'd4,
    CT_UNASSIGNED = 3'd5
  } code_type_e;

  typedef enum logic [2:0] {
    REG_MIN_LEN     = 3'd0,
    REG_MIN_GEO     = 3'd1,
    REG_MIN_GLOBAL  = 3'd2,
    REG_MIN_NETWORK = 3'd3,
    REG_MIN_GROUP   = 3'd4
  } reg_idx_e;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    is_digit = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    is_space = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

### rtl/core/phone_number_string_parser.sv
// ----------------------------------------------------------------------------
// phone_number_string_parser
// Parses a '+'-prefixed telephone number one character per beat, looks up
// the country code type in a 1024-entry table and reports number and status.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tdata: table_index, table_type, char_code
//                                    tuser: command, tlast: char_last
//  m_axis    out  tvalid/tready      tdata: number_value, country_code, status
//  apb       in   psel/penable       five threshold registers at 4*i
//
//  One input beat per cycle, table writes and characters alike, while s_axis
//  is not stalled. The type table is a synchronous RAM with a registered
//  read; the looked-up type is taken from the read register in the cycle
//  after the read. A result passes through the finish stage, which resolves
//  the table read and the length checks, and then the output register.
//  Reset clears the parse state and registers; the table is not cleared and
//  needs writing before use. s_axis stalls only while both the finish stage
//  and the output register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module phone_number_string_parser #(
  parameter int unsigned MAX_DIGITS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [9:0] table_index, [12:10] table_type, [20:13] char_code, [23:21] zero
  input  wire logic [23:0] s_axis_tdata_i,
  // [0] command
  input  wire logic        s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,

  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [49:0] number_value, [59:50] country_code, [63:60] status
  output      logic [63:0] m_axis_tdata_o,

  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output      logic [31:0] prdata_o,
  output      logic        pready_o
);

  localparam int unsigned DcntW = $clog2(MAX_DIGITS + 1);

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  logic [4:0] min_len_q;
  logic [3:0] min_geo_q, min_global_q, min_network_q, min_group_q;
  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_idx  = paddr_i[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q     <= 5'd3;
      min_geo_q     <= 4'd1;
      min_global_q  <= 4'd1;
      min_network_q <= 4'd1;
      min_group_q   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        pnsp_pkg::REG_MIN_LEN:     min_len_q     <= pwdata_i[4:0];
        pnsp_pkg::REG_MIN_GEO:     min_geo_q     <= pwdata_i[3:0];
        pnsp_pkg::REG_MIN_GLOBAL:  min_global_q  <= pwdata_i[3:0];
        pnsp_pkg::REG_MIN_NETWORK: min_network_q <= pwdata_i[3:0];
        pnsp_pkg::REG_MIN_GROUP:   min_group_q   <= pwdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pnsp_pkg::REG_MIN_LEN:     prdata_o = {27'd0, min_len_q};
      pnsp_pkg::REG_MIN_GEO:     prdata_o = {28'd0, min_geo_q};
      pnsp_pkg::REG_MIN_GLOBAL:  prdata_o = {28'd0, min_global_q};
      pnsp_pkg::REG_MIN_NETWORK: prdata_o = {28'd0, min_network_q};
      pnsp_pkg::REG_MIN_GROUP:   prdata_o = {28'd0, min_group_q};
      default:                   prdata_o = 32'd0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Input decode
  // -------------------------------------------------------------------------
  logic                         in_acc, char_acc, tw_acc, last_acc;
  logic [pnsp_pkg::CodeW-1:0]   tw_index;
  logic [pnsp_pkg::TypeW-1:0]   tw_type;
  logic [pnsp_pkg::CharW-1:0]   ch;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign char_acc = in_acc && (s_axis_tuser_i == pnsp_pkg::CMD_CHAR);
  assign tw_acc   = in_acc && (s_axis_tuser_i == pnsp_pkg::CMD_TABLE_WRITE);
  assign last_acc = char_acc && s_axis_tlast_i;
  assign tw_index = s_axis_tdata_i[9:0];
  assign tw_type  = s_axis_tdata_i[12:10];
  assign ch       = s_axis_tdata_i[20:13];

  // -------------------------------------------------------------------------
  // Type table
  // -------------------------------------------------------------------------
  logic [pnsp_pkg::TypeW-1:0] type_mem [pnsp_pkg::TblDepth];
  logic [pnsp_pkg::TypeW-1:0] rdata_q;
  logic                       rd_en;
  logic [pnsp_pkg::CodeW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (tw_acc) begin
      type_mem[tw_index] <= tw_type;
    end
    if (rd_en) begin
      rdata_q <= type_mem[rd_addr];
    end
  end

  // -------------------------------------------------------------------------
  // Parse state
  // -------------------------------------------------------------------------
  logic [pnsp_pkg::NumW-1:0]   num_q, num_d, num_next;
  logic [pnsp_pkg::CodeW-1:0]  code_q, code_d;
  logic [DcntW-1:0]            dcnt_q, dcnt_d, cdcnt_q, cdcnt_d;
  logic [pnsp_pkg::TypeW-1:0]  ctype_q, ctype_d, type_now;
  logic                        pend_q, pend_d;
  logic [pnsp_pkg::CharW-1:0]  prev_q, prev_d;
  logic                        left_q, left_d, right_q, right_d;
  logic [pnsp_pkg::CountW-1:0] cnt_q, cnt_d;
  pnsp_pkg::status_e           ferr_q, ferr_d, pre_st;

  // A pending lookup's type sits in the read register until folded in.
  assign type_now = pend_q ? rdata_q : ctype_q;
  assign num_next = {num_q[pnsp_pkg::NumW-4:0], 3'b000}
                  + {num_q[pnsp_pkg::NumW-2:0], 1'b0}
                  + {{(pnsp_pkg::NumW-4){1'b0}}, ch[3:0]};
  assign rd_addr  = num_next[pnsp_pkg::CodeW-1:0];

  always_comb begin
    num_d   = num_q;
    code_d  = code_q;
    dcnt_d  = dcnt_q;
    cdcnt_d = cdcnt_q;
    ctype_d = type_now;
    pend_d  = 1'b0;
    prev_d  = prev_q;
    left_d  = left_q;
    right_d = right_q;
    cnt_d   = cnt_q;
    ferr_d  = ferr_q;
    rd_en   = 1'b0;
    pre_st  = pnsp_pkg::ST_OK;

    if (char_acc) begin
      cnt_d = (cnt_q == pnsp_pkg::CountMax) ? cnt_q : cnt_q + 1'b1;
      if (cnt_q == '0) begin
        if (ch != pnsp_pkg::ChPlus) begin
          ferr_d = pnsp_pkg::ST_PREFIX;
        end
      end else if (ferr_q == pnsp_pkg::ST_OK) begin
        if (pnsp_pkg::is_digit(ch)) begin
          if (dcnt_q >= DcntW'(MAX_DIGITS)) begin
            ferr_d = pnsp_pkg::ST_LONG;
          end else begin
            dcnt_d = dcnt_q + 1'b1;
            num_d  = num_next;
            if (type_now == pnsp_pkg::CT_INVALID) begin
              if (num_next > pnsp_pkg::CcMax) begin
                ferr_d = pnsp_pkg::ST_RANGE;
              end else begin
                code_d  = num_next[pnsp_pkg::CodeW-1:0];
                cdcnt_d = dcnt_q + 1'b1;
                rd_en   = 1'b1;
                pend_d  = 1'b1;
                prev_d  = ch;
              end
            end else begin
              prev_d = ch;
            end
          end
        end else if (ch == pnsp_pkg::ChLeft) begin
          // no body character yet leaves prev at zero
          if (left_q || (prev_q == '0)) begin
            ferr_d = pnsp_pkg::ST_FORMAT;
          end else begin
            left_d = 1'b1;
            prev_d = ch;
          end
        end else if (ch == pnsp_pkg::ChRight) begin
          if (!left_q || right_q || (prev_q == pnsp_pkg::ChLeft)) begin
            ferr_d = pnsp_pkg::ST_FORMAT;
          end else begin
            right_d = 1'b1;
            prev_d  = ch;
          end
        end else if (!pnsp_pkg::is_space(ch)) begin
          ferr_d = pnsp_pkg::ST_FORMAT;
        end else begin
          prev_d = ch;
        end
      end

      // checks that do not need the table
      if (cnt_d < min_len_q) begin
        pre_st = pnsp_pkg::ST_SHORT;
      end else if (ferr_d != pnsp_pkg::ST_OK) begin
        pre_st = ferr_d;
      end else if (!pnsp_pkg::is_digit(prev_d)) begin
        pre_st = pnsp_pkg::ST_FORMAT;
      end else if (left_d && !right_d) begin
        pre_st = pnsp_pkg::ST_FORMAT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      code_q  <= '0;
      dcnt_q  <= '0;
      cdcnt_q <= '0;
      ctype_q <= pnsp_pkg::CT_INVALID;
      pend_q  <= 1'b0;
      prev_q  <= '0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
      cnt_q   <= '0;
      ferr_q  <= pnsp_pkg::ST_OK;
    end else if (last_acc) begin
      num_q   <= '0;
      code_q  <= '0;
      dcnt_q  <= '0;
      cdcnt_q <= '0;
      ctype_q <= pnsp_pkg::CT_INVALID;
      pend_q  <= 1'b0;
      prev_q  <= '0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
      cnt_q   <= '0;
      ferr_q  <= pnsp_pkg::ST_OK;
    end else begin
      num_q   <= num_d;
      code_q  <= code_d;
      dcnt_q  <= dcnt_d;
      cdcnt_q <= cdcnt_d;
      ctype_q <= ctype_d;
      pend_q  <= pend_d;
      prev_q  <= prev_d;
      left_q  <= left_d;
      right_q <= right_d;
      cnt_q   <= cnt_d;
      ferr_q  <= ferr_d;
    end
  end

  // -------------------------------------------------------------------------
  // Finish stage: resolves the last lookup and the subscriber length
  // -------------------------------------------------------------------------
  logic                       fin_valid_q, fin_pend_q, fin_adv;
  pnsp_pkg::status_e          fin_pre_q, fin_st;
  logic [pnsp_pkg::NumW-1:0]  fin_num_q;
  logic [pnsp_pkg::CodeW-1:0] fin_code_q;
  logic [DcntW-1:0]           fin_dcnt_q, fin_cdcnt_q, fin_sub;
  logic [pnsp_pkg::TypeW-1:0] fin_type_q, fin_type;
  logic [3:0]                 fin_need;

  logic       out_valid_q;
  logic [63:0] out_data_q;

  assign fin_adv         = fin_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !fin_valid_q || fin_adv;

  assign fin_type = fin_pend_q ? rdata_q : fin_type_q;
  assign fin_sub  = fin_dcnt_q - fin_cdcnt_q;

  always_comb begin
    case (fin_type)
      pnsp_pkg::CT_GEOGRAPHIC: fin_need = min_geo_q;
      pnsp_pkg::CT_GLOBAL_SVC: fin_need = min_global_q;
      pnsp_pkg::CT_NETWORK:    fin_need = min_network_q;
      default:                 fin_need = min_group_q;
    endcase

    if (fin_pre_q != pnsp_pkg::ST_OK) begin
      fin_st = fin_pre_q;
    end else if (fin_type == pnsp_pkg::CT_INVALID) begin
      fin_st = pnsp_pkg::ST_INVALID;
    end else if (fin_type >= pnsp_pkg::CT_UNASSIGNED) begin
      fin_st = pnsp_pkg::ST_UNASSIGNED;
    end else if (fin_dcnt_q <= fin_cdcnt_q) begin
      fin_st = pnsp_pkg::ST_NOSUB;
    end else if (5'(fin_sub) < 5'(fin_need)) begin
      fin_st = pnsp_pkg::ST_LENGTH;
    end else begin
      fin_st = pnsp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      fin_pend_q  <= 1'b0;
    end else begin
      if (last_acc) begin
        fin_valid_q <= 1'b1;
        fin_pend_q  <= rd_en;
      end else begin
        if (fin_adv) begin
          fin_valid_q <= 1'b0;
        end
        fin_pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      fin_pre_q   <= pre_st;
      fin_num_q   <= num_d;
      fin_code_q  <= code_d;
      fin_dcnt_q  <= dcnt_d;
      fin_cdcnt_q <= cdcnt_d;
      fin_type_q  <= type_now;
    end else if (fin_pend_q) begin
      fin_type_q  <= rdata_q;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      if (fin_st == pnsp_pkg::ST_OK) begin
        out_data_q <= {fin_st, fin_code_q, fin_num_q};
      end else begin
        out_data_q <= {fin_st, {(pnsp_pkg::CodeW + pnsp_pkg::NumW){1'b0}}};
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_pend_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q || fin_pend_q) |-> $past(rd_en))
    else $error("lookup pending without a table read");

  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && fin_pend_q))
    else $error("two table lookups outstanding");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && tw_acc))
    else $error("table read and write in one cycle");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (fin_valid_q && out_valid_q))
    else $error("input stalled with room downstream");

  a_last_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> fin_valid_q)
    else $error("last character did not reach the finish stage");

endmodule

`default_nettype wire

### test/tb_phone_number_string_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phone_number_string_parser
// Loads the country code type table, then streams directed and random number
// strings through the parser under several threshold settings. A built-in
// parser model predicts the number, country code and status of every string,
// and each result beat is checked field by field, in order.
// ----------------------------------------------------------------------------

module tb_phone_number_string_parser;

  import pnsp_pkg::*;

  localparam int unsigned MaxDigits  = 15;
  localparam int unsigned CycleLimit = 250000;

  typedef struct {
    cmd_e             cmd;
    logic [CodeW-1:0] index;
    logic [TypeW-1:0] kind;
    logic [CharW-1:0] ch;
    logic             last;
  } pn_beat_t;

  typedef struct {
    logic [NumW-1:0]  number;
    logic [CodeW-1:0] cc;
    status_e          status;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [9:0] table_index, [12:10] table_type, [20:13] char_code, [23:21] zero
  logic [23:0] s_tdata = '0;
  // [0] command
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [49:0] number_value, [59:50] country_code, [63:60] status
  logic [63:0] m_tdata;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // test control
  pn_beat_t      beats_pending[$];
  pn_beat_t      beat_on_bus;
  parse_result_t results_due[$];
  int unsigned   n_errors = 0;
  int unsigned   chars_queued = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   feed_gap = 0;
  int unsigned   sink_gap = 0;
  int unsigned   hold_left = 0;
  logic          src_idle_en = 1'b1;
  logic          sink_idle_en = 1'b1;
  logic          sink_hold_req = 1'b0;

  // table entries written so far, in queue order
  bit                kind_set [TblDepth];

  // parser model state
  logic [TypeW-1:0]  kind_tbl [TblDepth];
  logic [4:0]        thr_reg [5] = '{5'd3, 5'd1, 5'd1, 5'd1, 5'd1};
  logic [NumW-1:0]   num_sum = '0;
  logic [CodeW-1:0]  cc_value = '0;
  logic [3:0]        ndigits = '0;
  logic [3:0]        cc_ndigits = '0;
  logic [TypeW-1:0]  cc_kind = CT_INVALID;
  logic [CharW-1:0]  last_ch = '0;
  logic              open_paren = 1'b0;
  logic              close_paren = 1'b0;
  logic [CountW-1:0] nchars = '0;
  status_e           err_latched = ST_OK;

  function automatic logic digit_char(input logic [CharW-1:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic void latch_error(input status_e e);
    if (err_latched == ST_OK) err_latched = e;
  endfunction

  function automatic void take_body_char(input logic [CharW-1:0] c);
    if (digit_char(c)) begin
      if (ndigits >= MaxDigits) begin
        latch_error(ST_LONG);
        return;
      end
      ndigits++;
      num_sum = num_sum * 50'd10 + 50'(c - 8'd48);
      if (cc_kind == CT_INVALID) begin
        // no valid code yet: the whole number so far is the candidate
        if (num_sum > 50'd999) begin
          latch_error(ST_RANGE);
          return;
        end
        cc_value = num_sum[CodeW-1:0];
        cc_kind = kind_tbl[cc_value];
        cc_ndigits = ndigits;
      end
    end else if (c == ChLeft) begin
      if (open_paren || last_ch == 8'd0) begin
        latch_error(ST_FORMAT);
        return;
      end
      open_paren = 1'b1;
    end else if (c == ChRight) begin
      if (!open_paren || close_paren || last_ch == ChLeft) begin
        latch_error(ST_FORMAT);
        return;
      end
      close_paren = 1'b1;
    end else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
      latch_error(ST_FORMAT);
      return;
    end
    last_ch = c;
  endfunction

  function automatic status_e closing_status();
    if (nchars < thr_reg[REG_MIN_LEN]) return ST_SHORT;
    if (err_latched != ST_OK) return err_latched;
    if (!digit_char(last_ch)) return ST_FORMAT;
    if (open_paren && !close_paren) return ST_FORMAT;
    if (cc_kind == CT_INVALID) return ST_INVALID;
    if (cc_kind >= CT_UNASSIGNED) return ST_UNASSIGNED;
    if (ndigits <= cc_ndigits) return ST_NOSUB;
    // subscriber minimum registers sit at the index of their code type
    if ({1'b0, ndigits - cc_ndigits} < thr_reg[cc_kind]) return ST_LENGTH;
    return ST_OK;
  endfunction

  function automatic void parse_beat(input pn_beat_t b);
    logic          first;
    parse_result_t res;
    if (b.cmd == CMD_TABLE_WRITE) begin
      kind_tbl[b.index] = b.kind;
      return;
    end
    first = (nchars == 0);
    if (nchars != CountMax) nchars++;
    if (first) begin
      if (b.ch != ChPlus) latch_error(ST_PREFIX);
    end else if (err_latched == ST_OK) begin
      take_body_char(b.ch);
    end
    if (!b.last) return;
    res.status = closing_status();
    res.number = (res.status == ST_OK) ? num_sum : '0;
    res.cc = (res.status == ST_OK) ? cc_value : '0;
    results_due.push_back(res);
    num_sum = '0;
    cc_value = '0;
    ndigits = '0;
    cc_ndigits = '0;
    cc_kind = CT_INVALID;
    last_ch = '0;
    open_paren = 1'b0;
    close_paren = 1'b0;
    nchars = '0;
    err_latched = ST_OK;
  endfunction

  // an invalid code below 100 lets a lookup reach its ten longer codes
  function automatic logic children_set(input int unsigned idx);
    if (idx >= 100) return 1'b1;
    for (int j = 0; j < 10; j++)
      if (!kind_set[idx * 10 + j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic queue_table_write(input logic [CodeW-1:0] idx, input logic [TypeW-1:0] kind);
    pn_beat_t b;
    kind_set[idx] = 1'b1;
    b.cmd = CMD_TABLE_WRITE;
    b.index = idx;
    b.kind = kind;
    b.ch = 8'($urandom_range(0, 255));
    b.last = 1'($urandom_range(0, 1));
    beats_pending.push_back(b);
  endtask

  // never turns a short code invalid while its longer codes are unwritten
  task automatic queue_random_table_write();
    int unsigned      idx;
    logic [TypeW-1:0] kind;
    idx = $urandom_range(0, TblDepth - 1);
    kind = 3'($urandom_range(0, 7));
    if (kind == CT_INVALID && !children_set(idx)) kind = 3'($urandom_range(1, 7));
    queue_table_write(10'(idx), kind);
  endtask

  // every code below 100, plus the ten longer codes under each invalid
  // two-digit code, so no lookup ever reaches an unwritten entry
  task automatic fill_table();
    logic [TypeW-1:0] lead [10];
    logic [TypeW-1:0] kind;
    for (int i = 0; i < 100; i++) begin
      if (i == 0) begin
        kind = CT_INVALID;
      end else if (i < 10) begin
        kind = ($urandom_range(0, 10) < 4) ? CT_INVALID : 3'($urandom_range(1, 7));
      end else if (lead[i / 10] == CT_INVALID && $urandom_range(0, 3) == 0) begin
        kind = CT_INVALID;
      end else begin
        kind = 3'($urandom_range(1, 7));
      end
      if (i < 10) lead[i] = kind;
      queue_table_write(10'(i), kind);
      if (i >= 10 && kind == CT_INVALID)
        for (int j = 0; j < 10; j++)
          queue_table_write(10'(i * 10 + j),
                            ($urandom_range(0, 1) == 0) ? CT_INVALID : 3'($urandom_range(1, 7)));
    end
  endtask

  task automatic queue_char(input logic [CharW-1:0] c, input logic last);
    pn_beat_t b;
    b.cmd = CMD_CHAR;
    b.index = 10'($urandom_range(0, 1023));
    b.kind = 3'($urandom_range(0, 7));
    b.ch = c;
    b.last = last;
    beats_pending.push_back(b);
  endtask

  task automatic queue_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], close && i == s.len() - 1);
  endtask

  function automatic logic [CharW-1:0] pick_blank();
    return ($urandom_range(0, 1) == 0) ? ChSpace : 8'($urandom_range(9, 13));
  endfunction

  // mostly well-formed numbers; some corrupted, some overlong, some noise
  task automatic queue_random_string();
    logic [CharW-1:0] txt[$];
    int kind, ndig, nzero, open_at, close_at, pos;
    kind = $urandom_range(0, 15);
    if (kind >= 14) begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      txt.push_back(ChPlus);
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(5, 13);
      if (kind == 13) ndig = $urandom_range(16, 18);
      nzero = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ndig) : 0;
      open_at = -1;
      close_at = -1;
      if (ndig >= 3 && $urandom_range(0, 2) == 0) begin
        open_at = $urandom_range(1, ndig - 2);
        close_at = $urandom_range(open_at + 1, ndig - 1);
      end
      for (int i = 0; i < ndig; i++) begin
        if (i == open_at) txt.push_back(ChLeft);
        if (i == close_at) txt.push_back(ChRight);
        txt.push_back((i < nzero) ? ChZero : ChZero + 8'($urandom_range(0, 9)));
        // occasional long blank runs push the char count to saturation
        if (i < ndig - 1 && $urandom_range(0, 3) == 0)
          repeat (($urandom_range(0, 11) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2))
            txt.push_back(pick_blank());
      end
      if (kind >= 10 && kind <= 12) begin
        pos = $urandom_range(0, txt.size());
        case ($urandom_range(0, 4))
          0: txt.insert(pos, 8'($urandom_range(0, 255)));
          1: txt.insert(pos, ChLeft);
          2: txt.insert(pos, ChRight);
          3: txt.push_back(pick_blank());
          default: txt[0] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    foreach (txt[i]) begin
      if ($urandom_range(0, 15) == 0) queue_random_table_write();
      queue_char(txt[i], i == txt.size() - 1);
    end
    chars_queued += txt.size();
  endtask

  task automatic queue_random_chars(input int unsigned n);
    chars_queued = 0;
    while (chars_queued < n) queue_random_string();
  endtask

  task automatic apb_cycle(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_threshold(input reg_idx_e idx);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, 32'd0, rd);
    if (rd !== 32'(thr_reg[idx]))
      flag_error("register readback", 64'(rd), 64'(thr_reg[idx]));
  endtask

  task automatic write_threshold(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] mask, rd;
    mask = (idx == REG_MIN_LEN) ? 32'h1f : 32'hf;
    thr_reg[idx] = 5'(val & mask);
    // junk above the register width must be dropped
    apb_cycle(1'b1, idx, ($urandom() & ~mask) | (val & mask), rd);
    check_threshold(idx);
  endtask

  task automatic set_thresholds(input int len, input int geo, input int glob,
                                input int net, input int grp);
    write_threshold(REG_MIN_LEN, len);
    write_threshold(REG_MIN_GEO, geo);
    write_threshold(REG_MIN_GLOBAL, glob);
    write_threshold(REG_MIN_NETWORK, net);
    write_threshold(REG_MIN_GROUP, grp);
  endtask

  // waits until every queued beat is in and every result is out; looked at
  // on the falling edge, once the driver's updates have settled
  task automatic drain();
    while (beats_pending.size() != 0 || s_tvalid || results_due.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  phone_number_string_parser i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // input side: model is advanced on each accepted beat
  always @(posedge clk) begin : feed_p
    logic offering;
    offering = s_tvalid;
    if (s_tvalid && s_tready) begin
      parse_beat(beat_on_bus);
      offering = 1'b0;
    end
    if (!offering) begin
      if (feed_gap != 0) begin
        feed_gap--;
      end else if (beats_pending.size() != 0) begin
        beat_on_bus = beats_pending.pop_front();
        s_tdata <= {3'b000, beat_on_bus.ch, beat_on_bus.kind, beat_on_bus.index};
        s_tuser <= beat_on_bus.cmd;
        s_tlast <= beat_on_bus.last;
        offering = 1'b1;
        if (src_idle_en && $urandom_range(0, 9) == 0) feed_gap = $urandom_range(1, 17);
      end
    end
    s_tvalid <= offering;
  end

  // output side: checks each result beat and paces tready
  always @(posedge clk) begin : sink_p
    logic          take;
    parse_result_t want;
    if (m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        flag_error("result with no string pending", m_tdata, 64'd0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[49:0] !== want.number)
          flag_error("number_value", 64'(m_tdata[49:0]), 64'(want.number));
        if (m_tdata[59:50] !== want.cc)
          flag_error("country_code", 64'(m_tdata[59:50]), 64'(want.cc));
        if (m_tdata[63:60] !== want.status)
          flag_error("status", 64'(m_tdata[63:60]), 64'(want.status));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      take = 1'b0;
    end else if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      hold_left = 399;
      take = 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      take = 1'b0;
    end else begin
      take = 1'b1;
      if (sink_idle_en && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 17);
    end
    m_tready <= take;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = REG_MIN_LEN; i <= REG_MIN_GROUP; i++) check_threshold(reg_idx_e'(i));

    fill_table();

    // directed strings at reset thresholds
    queue_text("+", 1'b1);
    queue_text("1+2", 1'b1);
    queue_text("+(1", 1'b1);
    queue_text("+1()2", 1'b1);
    queue_text("+1)2", 1'b1);
    queue_text("+1(2", 1'b1);
    queue_text("+1 ", 1'b1);
    queue_text("+", 1'b0);
    queue_char(8'h00, 1'b0);
    queue_text("1", 1'b1);
    queue_text("+", 1'b0);
    queue_char(8'hff, 1'b0);
    queue_text("1", 1'b1);
    drain();

    set_thresholds(2, 1, 1, 1, 1);
    queue_random_chars(180);
    drain();

    set_thresholds(17, 15, 15, 15, 15);
    queue_random_chars(100);
    drain();

    // receiver holds off long enough to back the parser up to its input
    set_thresholds($urandom_range(2, 17), $urandom_range(1, 15), $urandom_range(1, 15),
                   $urandom_range(1, 15), $urandom_range(1, 15));
    src_idle_en = 1'b0;
    queue_random_chars(180);
    sink_hold_req = 1'b1;
    drain();

    set_thresholds($urandom_range(2, 6), $urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 4), $urandom_range(1, 4));
    sink_idle_en = 1'b0;
    queue_random_chars(180);
    drain();

    repeat (10) @(posedge clk);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
